### design/srld_pkg.sv
package srld_pkg;

    // Field widths
    localparam int BYTE_W       = 8;
    localparam int OFFSET_W     = 24;
    localparam int SKIP_W       = 25;
    localparam int CFG_W        = 25;
    localparam int SIZE_ACC_W   = 32;

    // Framing constants
    localparam int HEADER_BYTES = 8;
    localparam int HDR_IDX_W    = 3;
    localparam int MIN_SIZE     = 12;
    localparam int HUNT_SLACK   = 4;
    localparam logic [BYTE_W-1:0] SYNC_HI = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_LO = 8'h00;

    // Size limit register
    localparam logic [CFG_W-1:0] EFF_CAP        = CFG_W'(1) << OFFSET_W;
    localparam logic [CFG_W-1:0] CFG_RESET      = CFG_W'(1048576);
    localparam logic [CFG_W-1:0] HUNT_LIM_RESET = CFG_RESET + CFG_W'(HUNT_SLACK);

    // Command queue
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_SIZE,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_FF1,
        HS_FF2,
        HS_ZERO1
    } hunt_t;

    typedef enum logic [1:0] {
        ST_RECORD     = 2'd0,
        ST_HUNT_LIMIT = 2'd1,
        ST_BAD_SIZE   = 2'd2,
        ST_STREAM_END = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_BYTE_ERR,
        CMD_ERR,
        CMD_HEADER
    } cmd_kind_t;

    // One queued command: expands to one, two or eight result transactions
    typedef struct packed {
        cmd_kind_t                          kind;
        logic [HEADER_BYTES*BYTE_W-1:0]     data;
        logic [OFFSET_W-1:0]                offset;
        logic                               rec_end;
        status_t                            status;
        logic [SKIP_W-1:0]                  skipped;
    } cmd_t;

endpackage

### design/srld_if.sv
interface srld_raw_if;
    import srld_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface srld_rec_if;
    import srld_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   record_byte;
    logic [OFFSET_W-1:0] byte_offset;
    logic                record_end;
    logic                run_end;
    logic [1:0]          status;
    logic [SKIP_W-1:0]   skipped_bytes;

    modport source (output valid, output record_byte, output byte_offset,
                    output record_end, output run_end, output status,
                    output skipped_bytes, input ready);
    modport sink   (input valid, input record_byte, input byte_offset,
                    input record_end, input run_end, input status,
                    input skipped_bytes, output ready);
endinterface

### design/sync_length_record_deframer_top.sv
// A result is registered: its command passes through the command queue, then the output register.
// Throughput: one input byte per cycle while the four-entry command queue has room; the
// output register gives one result per cycle while the receiver is ready; a sync makes eight
// results and a bad size two, so the queue fills when these bursts outpace the output.
// Reset (rst_n, asynchronous, active low): hunt restarts, header ring clears to zeros, size
// limit returns to 1048576, queue and output register empty.
module sync_length_record_deframer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    srld_raw_if.sink                       raw,
    srld_rec_if.source                     framed,
    input  logic                           cfg_wr_en,
    input  logic [srld_pkg::CFG_W-1:0]     cfg_wr_data
);
    import srld_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Classify bytes and track framing
    srld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw         (raw),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // Decouple front and back
    srld_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Expand commands into result transactions
    srld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .framed   (framed)
    );

endmodule

### design/srld_front.sv
module srld_front (
    input  logic                           clk,
    input  logic                           rst_n,
    srld_raw_if.sink                       raw,
    input  logic                           cfg_wr_en,
    input  logic [srld_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           q_full,
    output logic                           q_push,
    output srld_pkg::cmd_t                 q_cmd
);
    import srld_pkg::*;

    logic [CFG_W-1:0]               eff_limit_reg;
    logic [CFG_W-1:0]               hunt_limit_reg;
    logic [CFG_W-1:0]               cfg_eff;

    phase_t                         phase_reg, phase_next;
    hunt_t                          hunt_reg, hunt_next;
    logic [SKIP_W-1:0]              hunt_count_reg, hunt_count_next;
    logic [SIZE_ACC_W-1:0]          size_acc_reg, size_acc_next;
    logic [OFFSET_W-1:0]            offset_reg, offset_next;
    logic [HEADER_BYTES*BYTE_W-1:0] ring_reg, ring_next;

    logic                           accept;
    logic [BYTE_W-1:0]              b;
    logic [SKIP_W-1:0]              hunt_inc;
    logic [SKIP_W-1:0]              skip_src;
    logic [SKIP_W-1:0]              skipped;
    logic [SIZE_ACC_W-1:0]          acc_upd;
    logic                           sync_hit;
    logic                           limit_hit;
    logic                           size_done;
    logic                           size_bad;
    logic                           size_last;
    logic                           body_last;

    assign raw.ready = !q_full;
    assign accept    = raw.valid && !q_full;
    assign b         = raw.data_byte;

    // Saturate the size limit at write time
    assign cfg_eff = (cfg_wr_data > EFF_CAP) ? EFF_CAP : cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_limit_reg  <= CFG_RESET;
            hunt_limit_reg <= HUNT_LIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            eff_limit_reg  <= cfg_eff;
            hunt_limit_reg <= cfg_eff + CFG_W'(HUNT_SLACK);
        end
    end

    // Shift every data byte into the ring, oldest byte in the low lane
    assign ring_next = {b, ring_reg[HEADER_BYTES*BYTE_W-1:BYTE_W]};

    // Shared conditions
    assign hunt_inc  = hunt_count_reg + SKIP_W'(1);
    assign sync_hit  = (hunt_reg == HS_ZERO1) && (b == SYNC_LO);
    assign limit_hit = hunt_inc >= hunt_limit_reg;
    assign skip_src  = (phase_reg == PH_HUNT) ? hunt_inc : hunt_count_reg;
    assign skipped   = (skip_src > SKIP_W'(HEADER_BYTES))
                     ? skip_src - SKIP_W'(HEADER_BYTES) : '0;

    always_comb
    begin
        acc_upd = size_acc_reg;
        acc_upd[offset_reg[1:0]*BYTE_W +: BYTE_W] = b;
    end

    assign size_done = offset_reg[1:0] == 2'd3;
    assign size_bad  = (acc_upd < SIZE_ACC_W'(MIN_SIZE))
                    || (acc_upd > SIZE_ACC_W'(eff_limit_reg));
    assign size_last = acc_upd == SIZE_ACC_W'(MIN_SIZE);
    assign body_last = (SIZE_ACC_W'(offset_reg) + SIZE_ACC_W'(1)) >= size_acc_reg;

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        hunt_next       = hunt_reg;
        hunt_count_next = hunt_count_reg;
        size_acc_next   = size_acc_reg;
        offset_next     = offset_reg;
        if (accept)
        begin
            if (raw.stream_end)
            begin
                phase_next      = PH_HUNT;
                hunt_next       = HS_IDLE;
                hunt_count_next = '0;
                size_acc_next   = '0;
                offset_next     = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        hunt_count_next = hunt_inc;
                        unique case (hunt_reg)
                            HS_IDLE:  hunt_next = (b == SYNC_HI) ? HS_FF1 : HS_IDLE;
                            HS_FF1:   hunt_next = (b == SYNC_HI) ? HS_FF2 : HS_IDLE;
                            HS_FF2:   hunt_next = (b == SYNC_LO) ? HS_ZERO1 : HS_IDLE;
                            HS_ZERO1: hunt_next = HS_IDLE;
                            default:  hunt_next = HS_IDLE;
                        endcase
                        if (sync_hit)
                        begin
                            phase_next    = PH_SIZE;
                            size_acc_next = '0;
                            offset_next   = OFFSET_W'(HEADER_BYTES);
                        end
                        else if (limit_hit)
                        begin
                            phase_next      = PH_HUNT;
                            hunt_next       = HS_IDLE;
                            hunt_count_next = '0;
                            size_acc_next   = '0;
                            offset_next     = '0;
                        end
                    end
                    PH_SIZE:
                    begin
                        size_acc_next = acc_upd;
                        offset_next   = offset_reg + OFFSET_W'(1);
                        if (size_done)
                        begin
                            if (size_bad || size_last)
                            begin
                                phase_next      = PH_HUNT;
                                hunt_next       = HS_IDLE;
                                hunt_count_next = '0;
                                size_acc_next   = '0;
                                offset_next     = '0;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    default:
                    begin
                        if (body_last)
                        begin
                            phase_next      = PH_HUNT;
                            hunt_next       = HS_IDLE;
                            hunt_count_next = '0;
                            size_acc_next   = '0;
                            offset_next     = '0;
                        end
                        else
                        begin
                            offset_next = offset_reg + OFFSET_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    // Command to the back end
    always_comb
    begin
        q_push        = 1'b0;
        q_cmd.kind    = CMD_BYTE;
        q_cmd.data    = '0;
        q_cmd.offset  = offset_reg;
        q_cmd.rec_end = 1'b0;
        q_cmd.status  = ST_RECORD;
        q_cmd.skipped = skipped;
        if (accept)
        begin
            if (raw.stream_end)
            begin
                q_push        = 1'b1;
                q_cmd.kind    = CMD_ERR;
                q_cmd.offset  = '0;
                q_cmd.rec_end = 1'b1;
                q_cmd.status  = ST_STREAM_END;
                q_cmd.skipped = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (sync_hit)
                        begin
                            q_push       = 1'b1;
                            q_cmd.kind   = CMD_HEADER;
                            q_cmd.data   = ring_next;
                            q_cmd.offset = '0;
                        end
                        else if (limit_hit)
                        begin
                            q_push        = 1'b1;
                            q_cmd.kind    = CMD_ERR;
                            q_cmd.offset  = '0;
                            q_cmd.rec_end = 1'b1;
                            q_cmd.status  = ST_HUNT_LIMIT;
                            q_cmd.skipped = '0;
                        end
                    end
                    PH_SIZE:
                    begin
                        q_push                = 1'b1;
                        q_cmd.data[BYTE_W-1:0] = b;
                        if (size_done && size_bad)
                        begin
                            q_cmd.kind   = CMD_BYTE_ERR;
                            q_cmd.status = ST_BAD_SIZE;
                        end
                        else
                        begin
                            q_cmd.rec_end = size_done && size_last;
                        end
                    end
                    default:
                    begin
                        q_push                 = 1'b1;
                        q_cmd.data[BYTE_W-1:0] = b;
                        q_cmd.rec_end          = body_last;
                    end
                endcase
            end
        end
    end

    // Hold framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            hunt_reg       <= HS_IDLE;
            hunt_count_reg <= '0;
            size_acc_reg   <= '0;
            offset_reg     <= '0;
            ring_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hunt_reg       <= hunt_next;
            hunt_count_reg <= hunt_count_next;
            size_acc_reg   <= size_acc_next;
            offset_reg     <= offset_next;
            if (accept && !raw.stream_end)
            begin
                ring_reg <= ring_next;
            end
        end
    end

endmodule

### design/srld_cmd_fifo.sv
module srld_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  srld_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output srld_pkg::cmd_t  head_cmd,
    output logic            full,
    output logic            empty
);
    import srld_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg;
    logic [QIDX_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QDEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QIDX_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QIDX_W'(1);
            end
        end
    end

    // Store commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/srld_back.sv
module srld_back (
    input  logic            clk,
    input  logic            rst_n,
    input  srld_pkg::cmd_t  head_cmd,
    input  logic            q_empty,
    output logic            q_pop,
    srld_rec_if.source      framed
);
    import srld_pkg::*;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 rec_end_reg;
    logic                 run_end_reg;
    status_t              status_reg;
    logic [SKIP_W-1:0]    skipped_reg;
    logic [HDR_IDX_W-1:0] sub_reg;

    logic                 load;
    logic                 last_sub;
    logic [BYTE_W-1:0]    byte_next;
    logic [OFFSET_W-1:0]  offset_next;
    logic                 rec_end_next;
    status_t              status_next;
    logic [SKIP_W-1:0]    skipped_next;

    assign load  = !q_empty && (!out_valid_reg || framed.ready);
    assign q_pop = load && last_sub;

    // Expand the head command into one transaction per step
    always_comb
    begin
        last_sub     = 1'b1;
        byte_next    = head_cmd.data[BYTE_W-1:0];
        offset_next  = head_cmd.offset;
        rec_end_next = head_cmd.rec_end;
        status_next  = head_cmd.status;
        skipped_next = head_cmd.skipped;
        unique case (head_cmd.kind)
            CMD_HEADER:
            begin
                last_sub     = sub_reg == HDR_IDX_W'(HEADER_BYTES - 1);
                byte_next    = head_cmd.data[sub_reg*BYTE_W +: BYTE_W];
                offset_next  = OFFSET_W'(sub_reg);
                rec_end_next = 1'b0;
                status_next  = ST_RECORD;
            end
            CMD_BYTE_ERR:
            begin
                last_sub = sub_reg != '0;
                if (sub_reg == '0)
                begin
                    rec_end_next = 1'b0;
                    status_next  = ST_RECORD;
                end
                else
                begin
                    byte_next    = '0;
                    offset_next  = '0;
                    rec_end_next = 1'b1;
                    skipped_next = '0;
                end
            end
            CMD_ERR:
            begin
                byte_next = '0;
            end
            default:
            begin
                status_next = ST_RECORD;
            end
        endcase
    end

    // Advance output register and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sub_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                sub_reg       <= last_sub ? '0 : sub_reg + HDR_IDX_W'(1);
            end
            else if (framed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= byte_next;
            offset_reg  <= offset_next;
            rec_end_reg <= rec_end_next;
            run_end_reg <= last_sub;
            status_reg  <= status_next;
            skipped_reg <= skipped_next;
        end
    end

    assign framed.valid         = out_valid_reg;
    assign framed.record_byte   = byte_reg;
    assign framed.byte_offset   = offset_reg;
    assign framed.record_end    = rec_end_reg;
    assign framed.run_end       = run_end_reg;
    assign framed.status        = status_reg;
    assign framed.skipped_bytes = skipped_reg;

endmodule

### dv/srld_record_checker.sv
`timescale 1ns / 1ps

module srld_record_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    srld_raw_if                        raw,
    srld_rec_if                        framed,
    input  logic                       cfg_wr_en,
    input  logic [srld_pkg::CFG_W-1:0] cfg_wr_data,
    output int                         mismatches,
    output int                         beats_outstanding
);
    import srld_pkg::*;

    // One predicted record transaction
    typedef struct packed {
        logic [BYTE_W-1:0]   rec_byte;
        logic [OFFSET_W-1:0] offset;
        logic                rec_end;
        logic                run_last;
        status_t             status;
        logic [SKIP_W-1:0]   skipped;
    } record_beat_t;

    // Predicted deframer state
    logic [CFG_W-1:0]     size_limit;
    int                   sync_match;
    logic [BYTE_W-1:0]    tail_bytes [HEADER_BYTES];
    logic [HDR_IDX_W-1:0] tail_ptr;
    int unsigned          hunt_len;
    phase_t               phase;
    logic [31:0]          size_word;
    int unsigned          rec_offset;

    record_beat_t expected_beats [$];

    function automatic record_beat_t make_beat(input logic [BYTE_W-1:0] value,
                                               input int unsigned off,
                                               input logic rend,
                                               input status_t st,
                                               input logic [SKIP_W-1:0] skip);
        record_beat_t beat;
        beat.rec_byte = value;
        beat.offset   = OFFSET_W'(off);
        beat.rec_end  = rend;
        beat.run_last = 1'b0;
        beat.status   = st;
        beat.skipped  = skip;
        return beat;
    endfunction

    function automatic logic [SKIP_W-1:0] bytes_skipped();
        return (hunt_len > HEADER_BYTES) ? SKIP_W'(hunt_len - HEADER_BYTES) : '0;
    endfunction

    function automatic void restart_hunt();
        phase      = PH_HUNT;
        sync_match = 0;
        hunt_len   = 0;
        size_word  = '0;
        rec_offset = 0;
    endfunction

    function automatic void reset_deframer();
        int i;
        size_limit = CFG_RESET;
        for (i = 0; i < HEADER_BYTES; i++)
        begin
            tail_bytes[i] = '0;
        end
        tail_ptr = '0;
        restart_hunt();
        expected_beats.delete();
    endfunction

    // Advance the deframer by one input transaction and queue what it emits
    task automatic step_deframer(input logic [BYTE_W-1:0] b, input logic se);
        record_beat_t         beats [$];
        logic [31:0]          eff;
        logic [31:0]          sz;
        logic                 bad;
        logic                 last;
        logic [HDR_IDX_W-1:0] idx;
        int                   i;
        int unsigned          sh;
        eff = (size_limit > EFF_CAP) ? 32'(EFF_CAP) : 32'(size_limit);
        if (se)
        begin
            beats.push_back(make_beat('0, 0, 1'b1, ST_STREAM_END, '0));
            restart_hunt();
        end
        else
        begin
            // The ring takes every data byte in every phase
            tail_bytes[tail_ptr] = b;
            tail_ptr = tail_ptr + 1'b1;
            case (phase)
                PH_HUNT:
                begin
                    hunt_len++;
                    if ((sync_match < 2 && b == SYNC_HI) || (sync_match >= 2 && b == SYNC_LO))
                        sync_match++;
                    else
                        sync_match = 0;
                    if (sync_match == 4)
                    begin
                        // Emit the ring oldest first: four header bytes, then the sync
                        for (i = 0; i < HEADER_BYTES; i++)
                        begin
                            idx = tail_ptr + HDR_IDX_W'(i);
                            beats.push_back(make_beat(tail_bytes[idx], i, 1'b0, ST_RECORD,
                                                      bytes_skipped()));
                        end
                        sync_match = 0;
                        phase      = PH_SIZE;
                        size_word  = '0;
                        rec_offset = HEADER_BYTES;
                    end
                    else if (hunt_len >= eff + HUNT_SLACK)
                    begin
                        beats.push_back(make_beat('0, 0, 1'b1, ST_HUNT_LIMIT, '0));
                        restart_hunt();
                    end
                end
                PH_SIZE:
                begin
                    sh = ((rec_offset - HEADER_BYTES) & 3) * 8;
                    size_word = size_word | (32'(b) << sh);
                    if (rec_offset >= HEADER_BYTES + 3)
                    begin
                        sz   = size_word;
                        bad  = (sz < MIN_SIZE) || (sz > eff);
                        last = !bad && (sz == MIN_SIZE);
                        beats.push_back(make_beat(b, rec_offset, last, ST_RECORD,
                                                  bytes_skipped()));
                        if (bad)
                        begin
                            beats.push_back(make_beat('0, 0, 1'b1, ST_BAD_SIZE, '0));
                            restart_hunt();
                        end
                        else if (last)
                            restart_hunt();
                        else
                        begin
                            phase = PH_BODY;
                            rec_offset++;
                        end
                    end
                    else
                    begin
                        beats.push_back(make_beat(b, rec_offset, 1'b0, ST_RECORD,
                                                  bytes_skipped()));
                        rec_offset++;
                    end
                end
                default:
                begin
                    last = (rec_offset + 1 >= size_word);
                    beats.push_back(make_beat(b, rec_offset, last, ST_RECORD, bytes_skipped()));
                    if (last)
                        restart_hunt();
                    else
                        rec_offset++;
                end
            endcase
        end
        // Mark the last transaction caused by this input
        if (beats.size() > 0)
            beats[beats.size()-1].run_last = 1'b1;
        foreach (beats[i])
            expected_beats.push_back(beats[i]);
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Compare output transactions, then predict from input transactions
    always @(posedge clk or negedge rst_n)
    begin
        record_beat_t want;
        if (!rst_n)
        begin
            reset_deframer();
            mismatches        = 0;
            beats_outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
                size_limit = cfg_wr_data;
            if (framed.valid && framed.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected record transaction: byte 0x%0h offset %0d status %0d",
                           framed.record_byte, framed.byte_offset, framed.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("record_byte", 32'(want.rec_byte), 32'(framed.record_byte));
                    check_field("byte_offset", 32'(want.offset), 32'(framed.byte_offset));
                    check_field("record_end", 32'(want.rec_end), 32'(framed.record_end));
                    check_field("run_end", 32'(want.run_last), 32'(framed.run_end));
                    check_field("status", 32'(want.status), 32'(framed.status));
                    check_field("skipped_bytes", 32'(want.skipped), 32'(framed.skipped_bytes));
                end
            end
            if (raw.valid && raw.ready)
                step_deframer(raw.data_byte, raw.stream_end);
            beats_outstanding = expected_beats.size();
        end
    end

endmodule

### dv/sync_length_record_deframer_top_tb.sv
`timescale 1ns / 1ps

module sync_length_record_deframer_top_tb;
    import srld_pkg::*;

    localparam int TOTAL_ITEMS    = 330;
    localparam int DIRECTED_ITEMS = 24;
    localparam int NUM_PHASES     = 6;
    localparam int HOLD_CYCLES    = 100;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] SYNC_WORD = {SYNC_LO, SYNC_LO, SYNC_HI, SYNC_HI};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    int          send_gap_pct;
    int          stall_pct;
    bit          hold_request;
    int          items_sent;
    logic [31:0] cur_limit;
    int          mismatches;
    int          beats_outstanding;

    srld_raw_if raw_ch ();
    srld_rec_if rec_ch ();

    sync_length_record_deframer_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .raw         (raw_ch),
        .framed      (rec_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    srld_record_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .raw               (raw_ch),
        .framed            (rec_ch),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .mismatches        (mismatches),
        .beats_outstanding (beats_outstanding)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_taken;
        hold_taken   = 1'b0;
        rec_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                rec_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                rec_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: end the run after too long without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((raw_ch.valid && raw_ch.ready) || (rec_ch.valid && rec_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("sync_length_record_deframer_top_tb: done, errors");
        $finish;
    end

    function automatic logic [31:0] phase_limit(input int p);
        case (p)
            0: return 32'd12;
            1: return 32'd0;
            2: return 32'h01FF_FFFF;
            3: return 32'h0100_0000;
            4: return 32'd40;
            default: return 32'(CFG_RESET);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        case ($urandom_range(0, 3))
            0: return SYNC_HI;
            1: return SYNC_LO;
            default: return BYTE_W'($urandom());
        endcase
    endfunction

    function automatic void set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_gap_pct = 51;
                stall_pct    = 0;
            end
            IDLE_RECEIVER:
            begin
                send_gap_pct = 0;
                stall_pct    = 51;
            end
            IDLE_BOTH:
            begin
                send_gap_pct = 38;
                stall_pct    = 38;
            end
            default:
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
        endcase
    endfunction

    // Offer one input transaction after a random gap; hold valid until accepted
    task automatic send_item(input logic [BYTE_W-1:0] d, input logic se);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            raw_ch.valid <= 1'b0;
            @(posedge clk);
        end
        raw_ch.valid      <= 1'b1;
        raw_ch.data_byte  <= d;
        raw_ch.stream_end <= se;
        do @(posedge clk); while (!raw_ch.ready);
        items_sent++;
    endtask

    task automatic send_le_word(input logic [31:0] w);
        int i;
        for (i = 0; i < 4; i++)
        begin
            send_item(w[8*i +: 8], 1'b0);
        end
    endtask

    // Stop offering and wait until every predicted transaction has arrived
    task automatic drain_results();
        raw_ch.valid <= 1'b0;
        do @(negedge clk); while (beats_outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_size_limit(input logic [CFG_W-1:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_limit = (v > EFF_CAP) ? 32'(EFF_CAP) : 32'(v);
    endtask

    // One framed record: noise, header, sync, size, then body or abort if the size admits a body
    task automatic send_record();
        int          n;
        int          i;
        int          body_len;
        int          cut;
        int          pick;
        logic [31:0] size;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
        begin
            send_item(noise_byte(), 1'b0);
        end
        send_le_word($urandom());
        send_le_word(SYNC_WORD);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            size = 32'(MIN_SIZE) + $urandom_range(0, 24);
        else if (pick < 70)
            size = $urandom_range(0, MIN_SIZE - 1);
        else if (pick < 80)
            size = cur_limit + $urandom_range(0, 1);
        else if (pick < 88)
            size = cur_limit - $urandom_range(0, 1);
        else
            size = $urandom();
        send_le_word(size);
        if (size >= MIN_SIZE && size <= cur_limit && size > MIN_SIZE)
        begin
            body_len = int'(size) - MIN_SIZE;
            if (body_len > 40 || $urandom_range(0, 9) == 0)
            begin
                // Abort the record part way with a stream end
                cut = $urandom_range(0, (body_len < 8) ? body_len : 8);
                for (i = 0; i < cut; i++)
                begin
                    send_item(BYTE_W'($urandom()), 1'b0);
                end
                send_item(BYTE_W'($urandom()), 1'b1);
            end
            else
            begin
                for (i = 0; i < body_len; i++)
                begin
                    send_item(BYTE_W'($urandom()), 1'b0);
                end
            end
        end
    endtask

    task automatic send_traffic_burst();
        int pick;
        int n;
        int i;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            send_record();
        else if (pick < 80)
        begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
            begin
                send_item(noise_byte(), 1'b0);
            end
        end
        else if (pick < 88)
            send_item(BYTE_W'($urandom()), 1'b1);
        else if (cur_limit <= 40)
        begin
            // Run the hunt past its limit
            n = int'(cur_limit) + HUNT_SLACK + $urandom_range(0, 4);
            for (i = 0; i < n; i++)
            begin
                send_item(BYTE_W'($urandom()), 1'b0);
            end
        end
        else
            send_record();
    endtask

    initial
    begin
        int  p;
        int  target;
        bit  paused;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        raw_ch.valid      = 1'b0;
        raw_ch.data_byte  = '0;
        raw_ch.stream_end = 1'b0;
        hold_request      = 1'b0;
        items_sent        = 0;
        paused            = 1'b0;
        cur_limit         = 32'(CFG_RESET);
        set_idle_mode(IDLE_NONE);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Stream end with nothing hunted
        send_item(8'hA5, 1'b1);
        // Sync right after reset: header carries the cleared ring
        send_le_word(SYNC_WORD);
        // Size of exactly twelve ends at byte eleven
        send_le_word(32'd12);
        // Broken sync: no overlap retry, so this is only noise
        send_item(SYNC_HI, 1'b0);
        send_item(SYNC_HI, 1'b0);
        send_item(SYNC_HI, 1'b0);
        send_item(SYNC_LO, 1'b0);
        send_item(SYNC_LO, 1'b0);
        // Sync with skipped bytes, one body byte
        send_le_word(SYNC_WORD);
        send_le_word(32'd13);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b1);

        // Random phases over several size limits and idling modes
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_size_limit(CFG_W'(phase_limit(p)));
            set_idle_mode(idle_mode_t'(p % 4));
            if (p == 0)
                hold_request = 1'b1;
            target = DIRECTED_ITEMS + (p + 1) * (TOTAL_ITEMS - DIRECTED_ITEMS) / NUM_PHASES;
            while (items_sent < target)
            begin
                if (p == 3 && !paused && items_sent >= target - 25)
                begin
                    drain_results();
                    paused = 1'b1;
                end
                send_traffic_burst();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && beats_outstanding == 0)
            $display("sync_length_record_deframer_top_tb: done, clean");
        else
            $display("sync_length_record_deframer_top_tb: done, errors");
        $finish;
    end

endmodule
